/* sv/pfe_pkg.sv */
// shared types and codes for the pipe byte fifo
// no dependencies; imported by the core
package pfe_pkg;

	// operation carried by one input beat
	typedef enum logic [2:0] {
		ACT_OPEN_RD  = 3'd0,
		ACT_OPEN_WR  = 3'd1,
		ACT_CLOSE_RD = 3'd2,
		ACT_CLOSE_WR = 3'd3,
		ACT_WRITE    = 3'd4,
		ACT_READ     = 3'd5
	} action_t;

	// completion code carried by one result beat
	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_BUSY        = 3'd1,
		ST_EOF         = 3'd2,
		ST_WOULD_BLOCK = 3'd3,
		ST_BROKEN_PIPE = 3'd4
	} status_t;

	localparam int unsigned BYTE_W = 8;

endpackage

/* sv/pfe_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module pfe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic                                         re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* sv/pipe_byte_fifo_with_endpoints_core.sv */
// pipe byte fifo core: endpoint flags, pointers, count and result pipeline
// depends on pfe_pkg and pfe_ram
//
// Usage: each input beat (action, write_data) opens or closes the read or
// write end, stores one byte or takes one byte from a circular store of
// DEPTH bytes. Every input beat yields exactly one result beat carrying
// status, read_data (the byte taken on a good read, else zero) and
// fill_level (bytes held after the beat).
// Both channels are valid/ready. Endpoint flags, pointers and count update
// at the accepting edge; the store read is issued then and its data is
// registered in the store read port. A beat then passes the middle stage
// and the result register. Throughput is one beat per cycle while
// out_ready is high, set by the single store write and read ports.
// When out_ready is low the result register holds and one more beat can
// sit in the middle stage; in_ready then drops until the result drains.
// Reset clears both ends to closed, the pointers and the count; the store
// contents are left as they are and are never read before being written.
module pipe_byte_fifo_with_endpoints_core #(
	parameter int DEPTH = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [2:0]                            action,
	input  logic [pfe_pkg::BYTE_W-1:0]            write_data,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [2:0]                            status,
	output logic [pfe_pkg::BYTE_W-1:0]            read_data,
	output logic [$clog2(DEPTH+1)-1:0]            fill_level
);

	import pfe_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	// architectural state
	logic          rd_open_q, wr_open_q;
	logic [AW-1:0] rd_ptr_q, wr_ptr_q;
	logic [CW-1:0] count_q;

	// next state and result of the accepted beat
	logic          rd_open_d, wr_open_d;
	logic [AW-1:0] rd_ptr_d, wr_ptr_d;
	logic [CW-1:0] count_d;
	status_t       st_d;
	logic          take_byte, put_byte;

	// middle stage: waiting for store read data
	logic          valid_s1;
	status_t       status_s1;
	logic          took_s1;
	logic [CW-1:0] fill_s1;

	// result register
	logic              out_valid_q;
	status_t           out_status_q;
	logic [BYTE_W-1:0] out_data_q;
	logic [CW-1:0]     out_fill_q;

	logic              accept, s1_go;
	logic [BYTE_W-1:0] ram_rdata;

	// handshake
	assign s1_go    = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_go;
	assign accept   = in_valid && in_ready;

	// decode one beat against the current state
	always_comb begin
		rd_open_d = rd_open_q;
		wr_open_d = wr_open_q;
		rd_ptr_d  = rd_ptr_q;
		wr_ptr_d  = wr_ptr_q;
		count_d   = count_q;
		st_d      = ST_OK;
		take_byte = 1'b0;
		put_byte  = 1'b0;
		unique case (action_t'(action))
			ACT_OPEN_RD: begin
				if (rd_open_q) st_d = ST_BUSY;
				else rd_open_d = 1'b1;
			end
			ACT_OPEN_WR: begin
				if (wr_open_q) st_d = ST_BUSY;
				else wr_open_d = 1'b1;
			end
			ACT_CLOSE_RD: rd_open_d = 1'b0;
			ACT_CLOSE_WR: wr_open_d = 1'b0;
			ACT_WRITE: begin
				if (count_q == CNT_FULL) begin
					st_d = rd_open_q ? ST_WOULD_BLOCK : ST_BROKEN_PIPE;
				end else begin
					put_byte = 1'b1;
					wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
					count_d  = count_q + 1'b1;
				end
			end
			ACT_READ: begin
				if (count_q == '0) begin
					st_d = wr_open_q ? ST_WOULD_BLOCK : ST_EOF;
				end else begin
					take_byte = 1'b1;
					rd_ptr_d  = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
					count_d   = count_q - 1'b1;
				end
			end
			default: ;
		endcase
	end

	// byte store
	pfe_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (accept && put_byte),
		.waddr(wr_ptr_q),
		.wdata(write_data),
		.re   (accept && take_byte),
		.raddr(rd_ptr_q),
		.rdata(ram_rdata)
	);

	// endpoint flags, pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_open_q <= 1'b0;
			wr_open_q <= 1'b0;
			rd_ptr_q  <= '0;
			wr_ptr_q  <= '0;
			count_q   <= '0;
		end else if (accept) begin
			rd_open_q <= rd_open_d;
			wr_open_q <= wr_open_d;
			rd_ptr_q  <= rd_ptr_d;
			wr_ptr_q  <= wr_ptr_d;
			count_q   <= count_d;
		end
	end

	// stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) valid_s1 <= 1'b1;
			else if (s1_go) valid_s1 <= 1'b0;
			if (s1_go) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// middle stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= st_d;
			took_s1   <= take_byte;
			fill_s1   <= count_d;
		end
	end

	// result register payload, store data merged here
	always_ff @(posedge clk) begin
		if (s1_go) begin
			out_status_q <= status_s1;
			out_data_q   <= took_s1 ? ram_rdata : '0;
			out_fill_q   <= fill_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign read_data  = out_data_q;
	assign fill_level = out_fill_q;

endmodule
